// File: sv/stes_pkg.sv
package stes_pkg;

  localparam int MaxVerticesDef = 16;
  localparam int MaxEdgesDef    = 64;
  localparam int WeightBitsDef  = 16;

  localparam int VtxW   = 4;
  localparam int CostW  = 16;
  localparam int CountW = 5;
  localparam int MaskW  = 16;
  localparam int OutW   = 20;
  localparam int CfgIdxW = 1;

  localparam logic [OutW-1:0] OutMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VERTEX_COUNT  = 1'b0,
    REG_REQUIRED_MASK = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic ld_we;
    logic sort_init;
    logic key_rd;
    logic key_ld;
    logic shift_rd;
    logic wr_key;
    logic wr_shift;
    logic srch_init;
    logic sub_init;
    logic edge_rd;
    logic sub_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_zero;
    logic gt;
    logic k_done;
    logic last_sub;
  } sts_t;

endpackage

// File: sv/stes_ctrl.sv
module stes_ctrl import stes_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_edge_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o,
  output logic out_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_KEY_RD, S_KEY, S_SHIFT_RD, S_SHIFT, S_SUB_INIT, S_RUN, S_SUB_END, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && last_edge_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.ld_we = 1'b1;
          if (last_edge_i) begin
            cmd_o.sort_init = 1'b1;
            state_d = S_KEY_RD;
          end
        end
      end
      S_KEY_RD: begin
        if (sts_i.i_done) begin
          cmd_o.srch_init = 1'b1;
          state_d = S_SUB_INIT;
        end else begin
          cmd_o.key_rd = 1'b1;
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        cmd_o.key_ld = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (sts_i.j_zero) begin
          cmd_o.wr_key = 1'b1;
          state_d = S_KEY_RD;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts_i.gt) begin
          cmd_o.wr_shift = 1'b1;
          state_d = S_SHIFT_RD;
        end else begin
          cmd_o.wr_key = 1'b1;
          state_d = S_KEY_RD;
        end
      end
      S_SUB_INIT: begin
        cmd_o.sub_init = 1'b1;
        state_d = S_RUN;
      end
      S_RUN: begin
        if (sts_i.k_done) begin
          state_d = S_SUB_END;
        end else begin
          cmd_o.edge_rd = 1'b1;
        end
      end
      S_SUB_END: begin
        cmd_o.sub_end = 1'b1;
        state_d = sts_i.last_sub ? S_DONE : S_SUB_INIT;
      end
      S_DONE: begin
        cmd_o.out_load = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/stes_dp.sv
module stes_dp import stes_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int MAX_EDGES    = MaxEdgesDef,
  parameter int WEIGHT_BITS  = WeightBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [MaskW-1:0]    cfg_data_i,
  input  logic [VtxW-1:0]     edge_from_i,
  input  logic [VtxW-1:0]     edge_to_i,
  input  logic [CostW-1:0]    edge_cost_i,
  output logic [OutW-1:0]     min_weight_o,
  output logic                found_o
);

  localparam int MV = MAX_VERTICES;
  localparam int VW = $clog2(MV);
  localparam int NW = $clog2(MV + 1);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = WEIGHT_BITS + VW;
  localparam int XW = (TW > OutW) ? TW : OutW;

  typedef struct packed {
    logic [VtxW-1:0]        from;
    logic [VtxW-1:0]        to;
    logic [WEIGHT_BITS-1:0] cost;
  } edge_t;

  logic [CountW-1:0] vcount_q;
  logic [MaskW-1:0]  req_mask_q;

  edge_t mem [MAX_EDGES];
  edge_t rdata_q, key_q, wdata;
  logic  we;
  logic [AW-1:0] waddr, raddr;

  logic [CW-1:0] cnt_q, i_q, j_q, k_q, j_m1;
  logic [MV-1:0] s_q, act_q, vmask, req, opt, s_next, act_new;
  logic [VW-1:0] label_q [MV];
  logic [NW-1:0] nodes_q, added_q, pop, n;
  logic [TW-1:0] total_q, best_q;
  logic          bfound_q, eval_v_q, feas;
  logic [OutW-1:0] min_weight_q;
  logic          found_q;

  logic          sa, sb, join_e;
  logic [VW-1:0] la, lb;

  always_comb begin
    if (int'(vcount_q) > MV) n = NW'(MV);
    else n = NW'(vcount_q);
    for (int v = 0; v < MV; v++) begin
      vmask[v] = (NW'(v) < n);
    end
  end

  for (genvar g = 0; g < MV; g++) begin : g_req
    if (g < MaskW) begin : g_in
      assign req[g] = vmask[g] & req_mask_q[g];
    end else begin : g_out
      assign req[g] = 1'b0;
    end
  end

  assign opt     = vmask & ~req;
  assign s_next  = (s_q - opt) & opt;
  assign act_new = req | s_q;

  always_comb begin
    pop = '0;
    for (int v = 0; v < MV; v++) begin
      pop = pop + NW'(act_new[v]);
    end
  end

  always_comb begin
    sa = 1'b0;
    sb = 1'b0;
    la = '0;
    lb = '0;
    for (int v = 0; v < MV; v++) begin
      if (int'(rdata_q.from) == v) begin
        sa = act_q[v];
        la = label_q[v];
      end
      if (int'(rdata_q.to) == v) begin
        sb = act_q[v];
        lb = label_q[v];
      end
    end
    join_e = eval_v_q && sa && sb && (la != lb);
  end

  assign j_m1 = CW'(j_q - 1'b1);

  always_comb begin
    we    = 1'b0;
    waddr = j_q[AW-1:0];
    wdata = key_q;
    if (cmd_i.ld_we) begin
      we    = (int'(cnt_q) < MAX_EDGES);
      waddr = cnt_q[AW-1:0];
      wdata = '{from: edge_from_i, to: edge_to_i, cost: WEIGHT_BITS'(edge_cost_i)};
    end else if (cmd_i.wr_key) begin
      we = 1'b1;
    end else if (cmd_i.wr_shift) begin
      we    = 1'b1;
      wdata = rdata_q;
    end
    if (cmd_i.key_rd) raddr = i_q[AW-1:0];
    else if (cmd_i.shift_rd) raddr = j_m1[AW-1:0];
    else raddr = k_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign feas = (nodes_q != '0) && (NW'(added_q + 1'b1) == nodes_q);

  assign sts_o.i_done   = (i_q >= cnt_q);
  assign sts_o.j_zero   = (j_q == '0);
  assign sts_o.gt       = (rdata_q.cost > key_q.cost);
  assign sts_o.k_done   = (k_q >= cnt_q);
  assign sts_o.last_sub = (s_next == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= CountW'(MaxVerticesDef);
      req_mask_q <= '0;
      cnt_q      <= '0;
      eval_v_q   <= 1'b0;
      bfound_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_VERTEX_COUNT:  vcount_q <= cfg_data_i[CountW-1:0];
          REG_REQUIRED_MASK: req_mask_q <= cfg_data_i;
          default: ;
        endcase
      end
      eval_v_q <= cmd_i.edge_rd;
      if (cmd_i.ld_we && (int'(cnt_q) < MAX_EDGES)) begin
        cnt_q <= CW'(cnt_q + 1'b1);
      end else if (cmd_i.out_load) begin
        cnt_q <= '0;
      end
      if (cmd_i.srch_init) begin
        bfound_q <= 1'b0;
      end else if (cmd_i.sub_end && feas) begin
        bfound_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        found_q <= bfound_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_init) i_q <= CW'(1);
    else if (cmd_i.wr_key) i_q <= CW'(i_q + 1'b1);
    if (cmd_i.key_ld) begin
      key_q <= rdata_q;
      j_q   <= i_q;
    end else if (cmd_i.wr_shift) begin
      j_q <= j_m1;
    end
    if (cmd_i.srch_init) begin
      s_q    <= '0;
      best_q <= '0;
    end else if (cmd_i.sub_end) begin
      s_q <= s_next;
      if (feas && (!bfound_q || (total_q < best_q))) best_q <= total_q;
    end
    if (cmd_i.sub_init) begin
      act_q   <= act_new;
      nodes_q <= pop;
      added_q <= '0;
      total_q <= '0;
      k_q     <= '0;
      for (int v = 0; v < MV; v++) begin
        label_q[v] <= VW'(v);
      end
    end else begin
      if (cmd_i.edge_rd) k_q <= CW'(k_q + 1'b1);
      if (join_e) begin
        total_q <= TW'(total_q + TW'(rdata_q.cost));
        added_q <= NW'(added_q + 1'b1);
        for (int v = 0; v < MV; v++) begin
          if (label_q[v] == lb) label_q[v] <= la;
        end
      end
    end
    if (cmd_i.out_load) begin
      if (!bfound_q) min_weight_q <= '0;
      else if (XW'(best_q) > XW'(OutMax)) min_weight_q <= OutMax;
      else min_weight_q <= OutW'(best_q);
    end
  end

  assign min_weight_o = min_weight_q;
  assign found_o      = found_q;

endmodule

// File: sv/steiner_tree_exhaustive_search.sv
// Edges are taken one word per cycle into an edge memory (one write, one read port)
// while the block is idle. The word with last_edge set starts the search and stalls
// the input until the result is built: an insertion sort of the stored edges in that
// memory (one memory read per compare step), then one pass of Kruskal's method per
// subset of the optional vertices, with edges streamed from the memory one per cycle.
// The result word waits in an output register, and edges for the next graph may be
// loaded while it does, though a word with last_edge set is held until the waiting
// result has been taken.
module steiner_tree_exhaustive_search import stes_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int MAX_EDGES    = MaxEdgesDef,
  parameter int WEIGHT_BITS  = WeightBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MaskW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VtxW-1:0]    edge_from_i,
  input  logic [VtxW-1:0]    edge_to_i,
  input  logic [CostW-1:0]   edge_cost_i,
  input  logic               last_edge_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OutW-1:0]    min_weight_o,
  output logic               found_o
);

  cmd_t cmd;
  sts_t sts;

  stes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_edge_i (last_edge_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  stes_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .edge_from_i  (edge_from_i),
    .edge_to_i    (edge_to_i),
    .edge_cost_i  (edge_cost_i),
    .min_weight_o (min_weight_o),
    .found_o      (found_o)
  );

`ifndef ASSERT_OFF
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_edge_i |=> in_stall_o)
    else $error("input not stalled after the last edge word");

  a_zero_when_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> min_weight_o == '0)
    else $error("weight not zero on a result without a tree");

  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised without a search in progress");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import stes_pkg::*;

  localparam int LimitCycles = 3000000;
  localparam int HoldCycles  = 3000;

  typedef struct {
    logic [VtxW-1:0]  from_v;
    logic [VtxW-1:0]  to_v;
    logic [CostW-1:0] cost;
    logic             last;
  } edge_word_t;

  typedef struct {
    logic [OutW-1:0] weight;
    logic            found;
  } tree_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = REG_VERTEX_COUNT;
  logic [MaskW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [VtxW-1:0]    edge_from_i = '0;
  logic [VtxW-1:0]    edge_to_i = '0;
  logic [CostW-1:0]   edge_cost_i = '0;
  logic               last_edge_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OutW-1:0]    min_weight_o;
  logic               found_o;

  steiner_tree_exhaustive_search dut (.*);

  always #6 clk_i = ~clk_i;

  edge_word_t   pending_edges[$];
  tree_result_t expected_trees[$];

  logic [4:0]  vertex_count = 5'd16;
  logic [15:0] required_mask = '0;
  logic [3:0]  stored_from[MaxEdgesDef];
  logic [3:0]  stored_to[MaxEdgesDef];
  logic [15:0] stored_cost[MaxEdgesDef];
  int          stored_count = 0;

  int  errors = 0;
  int  cycles = 0;
  int  graphs_checked = 0;
  int  edges_sent = 0;
  int  found_count = 0;
  bit  word_taken = 0;
  bit  tree_taken = 0;
  bit  hold_req = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  send_bursty = 0;
  bit  recv_bursty = 0;

  function automatic tree_result_t best_steiner_tree();
    logic [3:0]  sf[MaxEdgesDef];
    logic [3:0]  st[MaxEdgesDef];
    logic [15:0] sc[MaxEdgesDef];
    int          opt[16];
    int          parent[16];
    int          n, nopt, j, nodes, added, ra, rb, a, b;
    logic [15:0] req, active;
    longint      total, best;
    bit          found;
    tree_result_t res;
    n = (int'(vertex_count) > 16) ? 16 : int'(vertex_count);
    nopt = 0;
    req = '0;
    best = 0;
    found = 0;
    for (int i = 0; i < stored_count; i++) begin
      j = i;
      while (j > 0 && sc[j-1] > stored_cost[i]) begin
        sf[j] = sf[j-1];
        st[j] = st[j-1];
        sc[j] = sc[j-1];
        j--;
      end
      sf[j] = stored_from[i];
      st[j] = stored_to[i];
      sc[j] = stored_cost[i];
    end
    for (int v = 0; v < n; v++) begin
      if (required_mask[v]) req[v] = 1'b1;
      else opt[nopt++] = v;
    end
    for (int s = 0; s < (1 << nopt); s++) begin
      active = req;
      for (int k = 0; k < nopt; k++) if (s[k]) active[opt[k]] = 1'b1;
      nodes = 0;
      for (int v = 0; v < n; v++) begin
        parent[v] = v;
        if (active[v]) nodes++;
      end
      if (nodes == 0) continue;
      added = 0;
      total = 0;
      for (int i = 0; i < stored_count && added + 1 < nodes; i++) begin
        a = int'(sf[i]);
        b = int'(st[i]);
        if (a >= n || b >= n || !active[a] || !active[b]) continue;
        ra = a;
        while (parent[ra] != ra) ra = parent[ra];
        rb = b;
        while (parent[rb] != rb) rb = parent[rb];
        if (ra != rb) begin
          total += longint'(sc[i]);
          added++;
          parent[rb] = ra;
        end
      end
      if (added + 1 == nodes) begin
        if (!found || total < best) best = total;
        found = 1;
      end
    end
    res.found = found;
    res.weight = !found ? '0 : (best > OutMax) ? OutMax : best[OutW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    word_taken = 0;
    tree_taken = 0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      word_taken = 1;
      edges_sent++;
      if (stored_count < MaxEdgesDef) begin
        stored_from[stored_count] = edge_from_i;
        stored_to[stored_count] = edge_to_i;
        stored_cost[stored_count] = edge_cost_i;
        stored_count++;
      end
      if (last_edge_i) begin
        expected_trees.push_back(best_steiner_tree());
        stored_count = 0;
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tree_taken = 1;
      if (expected_trees.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: weight %0d found %0b",
                 $time, min_weight_o, found_o);
      end else begin
        tree_result_t exp_t;
        exp_t = expected_trees.pop_front();
        graphs_checked++;
        if (exp_t.found) found_count++;
        if (min_weight_o !== exp_t.weight) begin
          errors++;
          $display("%0t: min_weight expected %0d actual %0d",
                   $time, exp_t.weight, min_weight_o);
        end
        if (found_o !== exp_t.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, exp_t.found, found_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if ($urandom_range(0, 39) == 0) send_bursty = !send_bursty;
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_edges.size() > 0) begin
          edge_word_t w;
          w = pending_edges.pop_front();
          edge_from_i <= w.from_v;
          edge_to_i <= w.to_v;
          edge_cost_i <= w.cost;
          last_edge_i <= w.last;
          in_valid_i <= 1'b1;
          send_gap = send_bursty ? $urandom_range(0, 11) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 0;
        hold_left = HoldCycles;
      end
      if (tree_taken) begin
        if ($urandom_range(0, 9) == 0) recv_bursty = !recv_bursty;
        recv_gap = recv_bursty ? $urandom_range(0, 11) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [MaskW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_VERTEX_COUNT) vertex_count = data[4:0];
    else required_mask = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_edge(input int f, input int t, input int c, input bit l);
    edge_word_t w;
    w.from_v = VtxW'(f);
    w.to_v = VtxW'(t);
    w.cost = CostW'(c);
    w.last = l;
    pending_edges.push_back(w);
  endtask

  task automatic push_graph(input int ne);
    int n, span, c;
    n = (int'(vertex_count) > 16) ? 16 : int'(vertex_count);
    span = (n == 0) ? 15 : n - 1;
    for (int i = 0; i < ne; i++) begin
      case ($urandom_range(0, 3))
        0: c = $urandom_range(0, 3);
        1: c = 16'hFFFF - $urandom_range(0, 2);
        default: c = $urandom_range(0, 16'hFFFF);
      endcase
      if ($urandom_range(0, 9) == 0)
        push_edge($urandom_range(0, 15), $urandom_range(0, 15), c, i == ne - 1);
      else
        push_edge($urandom_range(0, span), $urandom_range(0, span), c, i == ne - 1);
    end
  endtask

  task automatic settle();
    while (pending_edges.size() > 0 || in_valid_i || expected_trees.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_config(input int vc, input int mask);
    settle();
    write_reg(REG_VERTEX_COUNT, MaskW'(vc));
    write_reg(REG_REQUIRED_MASK, MaskW'(mask));
  endtask

  initial begin
    int vc, n, nopt;
    logic [15:0] mask;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_config(4, 16'h0003);
    push_edge(0, 1, 0, 1);
    push_edge(0, 1, 16'hFFFF, 0);
    push_edge(1, 2, 16'hFFFF, 0);
    push_edge(2, 2, 1, 0);
    push_edge(0, 15, 1, 0);
    push_edge(0, 2, 16'hFFFF, 1);
    push_edge(2, 3, 5, 0);
    push_edge(3, 3, 5, 1);
    push_edge(1, 3, 7, 0);
    push_edge(0, 3, 7, 0);
    push_edge(1, 0, 7, 1);

    set_config(1, 16'h0000);
    push_edge(0, 0, 9, 1);
    push_edge(15, 0, 9, 1);

    set_config(0, 16'hFFFF);
    push_edge(0, 1, 3, 1);

    set_config(31, 16'hFFFF);
    for (int i = 0; i < 70; i++) push_edge(i % 16, (i + 1) % 16, 16'hFFFF, i == 69);
    for (int i = 0; i < 15; i++) push_edge(i, i + 1, 16'hFFFF, i == 14);

    set_config(16, 16'hFF00);
    repeat (3) push_graph($urandom_range(4, 12));

    set_config(16, 16'hFFF0);
    hold_req = 1;
    repeat (6) push_graph($urandom_range(1, 10));

    while (edges_sent + pending_edges.size() < 2000) begin
      case ($urandom_range(0, 9))
        0: vc = $urandom_range(0, 31);
        1: vc = 16;
        default: vc = $urandom_range(1, 16);
      endcase
      n = (vc > 16) ? 16 : vc;
      mask = 16'($urandom_range(0, 16'hFFFF));
      nopt = 0;
      for (int v = 0; v < n; v++) if (!mask[v]) nopt++;
      for (int v = 0; v < n && nopt > 4; v++) begin
        if (!mask[v]) begin
          mask[v] = 1'b1;
          nopt--;
        end
      end
      set_config(vc, int'(mask));
      repeat ($urandom_range(4, 12)) push_graph($urandom_range(1, 12));
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (expected_trees.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_trees.size());
    end
    $display("Checked %0d graphs from %0d edge words, %0d of them with a tree found,",
             graphs_checked, edges_sent, found_count);
    $display("across vertex counts 0 to 31, a full edge store and output back-pressure.");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/stes_pkg.sv
sv/stes_ctrl.sv
sv/stes_dp.sv
sv/steiner_tree_exhaustive_search.sv
tb/tb.sv
